// ===== rtl/pfb_pkg.sv =====
// shared constants, types and helpers for the page framebuffer blit and refresh block
package pfb_pkg;

    // panel geometry
    localparam int PAGES   = 8;
    localparam int COLUMNS = 128;
    localparam int DEPTH   = PAGES * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // page numbers run past the panel before clipping, so they get room up to 31
    localparam int PG_W  = 5;
    // pixel row width, page number plus bit within the page
    localparam int PX_W  = PG_W + 3;
    // column counts and column sums reach up to 382
    localparam int CNT_W = 9;

    localparam logic [PG_W-1:0]  PAGES_C = PG_W'(PAGES);
    localparam logic [PG_W-1:0]  LAST_PG = PG_W'(PAGES - 1);
    localparam logic [CNT_W-1:0] COLS_C  = CNT_W'(COLUMNS);

    // address commands sent ahead of each page
    localparam int         ADDR_CMDS  = 3;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_SRC   = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    // input payload fields
    typedef struct packed {
        logic [7:0] src_byte;
        logic [7:0] fill_byte;
        logic       fill_mode;
        logic [6:0] h;
        logic [7:0] w;
        logic [5:0] y;
        logic [6:0] x;
    } t_fields;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic begin_rgn;
        logic fill_step;
        logic src_start;
        logic draw_step;
        logic flush_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic fill_empty;
        logic fill_last;
        logic src_ok;
        logic draw_last;
        logic flush_has;
        logic out_free;
    } t_dp_stat;

    // command bytes reach the pins bit-reversed
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[7 - b] = v[b];
        end
        return r;
    endfunction

endpackage

// ===== rtl/pfb_ctrl.sv =====
// controller state machine: clearing pass, item dispatch, fill, draw and flush sequencing
module pfb_ctrl
    import pfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cmd     i_cmd_code,
    input  logic     i_fill_mode,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FILL  = 6'b000100,
        ST_DRAW  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_FLUSH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_cmd_code)
                        CMD_BEGIN: begin
                            o_cmd.begin_rgn = 1'b1;
                            if (i_fill_mode) n_state = ST_FILL;
                        end
                        CMD_SRC: begin
                            if (i_stat.src_ok) begin
                                o_cmd.src_start = 1'b1;
                                n_state = ST_DRAW;
                            end
                        end
                        CMD_FLUSH: begin
                            if (i_stat.flush_has) begin
                                o_cmd.flush_step = 1'b1;
                                n_state = ST_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                if (i_stat.fill_empty) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.fill_step = 1'b1;
                    if (i_stat.fill_last) n_state = ST_DRAIN;
                end
            end
            ST_DRAW: begin
                o_cmd.draw_step = 1'b1;
                if (i_stat.draw_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/pfb_dpath.sv =====
// datapath: frame memory, read-modify-write pipe, region and refresh registers, output register
module pfb_dpath
    import pfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_fields    i_fld,
    input  logic       i_m_tready,
    output t_dp_stat   o_stat,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tuser,
    output logic       o_m_tlast
);

    localparam int AX_W = PG_W + CNT_W;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ADDR = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [PG_W-1:0] pg,
                                                   input logic [CNT_W-1:0] col);
        logic [AX_W-1:0] a;
        a = AX_W'(pg) * AX_W'(COLUMNS) + AX_W'(col);
        return a[ADDR_W-1:0];
    endfunction

    // frame memory and its read data
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // region registers
    logic [6:0] r_gx;
    logic [5:0] r_gy;
    logic [7:0] r_gw;
    logic [6:0] r_gh;
    logic       r_gfill;
    logic [7:0] r_gpat;

    // source walk
    logic [4:0] r_src_k;
    logic [6:0] r_src_row;
    logic [7:0] r_src_byte;
    logic [2:0] r_bit;

    // fill walk
    logic [PG_W-1:0]  r_fp;
    logic [CNT_W-1:0] r_fi;

    // refresh walk
    logic [PG_W-1:0]  r_fl_page, n_fl_page;
    logic [CNT_W-1:0] r_fl_col, n_fl_col;
    t_phase           r_fl_phase, n_fl_phase;
    logic             r_pend_cmd, n_pend_cmd;
    logic [7:0]       r_pend_byte, n_pend_byte;
    logic             r_pend_last, n_pend_last;

    // clearing pass and write pipe
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [7:0]        r_wr_mask;
    logic              r_wr_bit;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_cmd;
    logic       r_out_last;

    // region derived values
    logic [CNT_W-1:0] w_gx9, w_room, w_dc;
    logic [PX_W-1:0]  w_yh, w_yh1;
    logic [PG_W-1:0]  w_yh_pg, w_yh1_pg, w_fl_last_pg, w_fill_last_pg, w_top_pg;

    assign w_gx9  = CNT_W'(r_gx);
    assign w_room = COLS_C - w_gx9;
    assign w_dc   = (w_gx9 >= COLS_C) ? '0
                  : ((CNT_W'(r_gw) < w_room) ? CNT_W'(r_gw) : w_room);

    assign w_yh     = PX_W'(r_gy) + PX_W'(r_gh);
    assign w_yh1    = w_yh - 1'b1;
    assign w_yh_pg  = PG_W'(w_yh >> 3);
    assign w_yh1_pg = PG_W'(w_yh1 >> 3);
    assign w_fl_last_pg   = (w_yh_pg < LAST_PG) ? w_yh_pg : LAST_PG;
    assign w_fill_last_pg = (w_yh1_pg < LAST_PG) ? w_yh1_pg : LAST_PG;
    assign w_top_pg       = PG_W'(r_gy >> 3);

    // fill position: rows of the region inside the current page
    logic [CNT_W-1:0] w_fcol;
    logic [7:0]       w_fmask;
    logic             w_fbit;

    assign w_fcol = w_gx9 + r_fi;
    assign w_fbit = r_gpat[3'd7 - r_fi[2:0]];

    always_comb begin
        logic [PX_W-1:0] frow;
        for (int b = 0; b < 8; b++) begin
            frow = {r_fp, 3'(b)};
            w_fmask[b] = (frow >= PX_W'(r_gy)) && (frow < w_yh);
        end
    end

    // draw position: one pixel of the current source byte
    logic [5:0]       w_rb, w_k_inc;
    logic [7:0]       w_di;
    logic [CNT_W-1:0] w_dcol;
    logic [PX_W-1:0]  w_drow;
    logic [PG_W-1:0]  w_dpg;
    logic             w_pix_ok;
    logic [7:0]       w_dmask;
    logic             w_dbit;

    assign w_rb     = 6'((9'(r_gw) + 9'd7) >> 3);
    assign w_k_inc  = 6'(r_src_k) + 6'd1;
    assign w_di     = {r_src_k, r_bit};
    assign w_dcol   = w_gx9 + CNT_W'(w_di);
    assign w_drow   = PX_W'(r_gy) + PX_W'(r_src_row);
    assign w_dpg    = PG_W'(w_drow >> 3);
    assign w_pix_ok = (w_di < r_gw) && (w_dcol < COLS_C) && (w_dpg < PAGES_C);
    assign w_dmask  = 8'b1 << w_drow[2:0];
    assign w_dbit   = r_src_byte[3'd7 - r_bit];

    // refresh walk, one bus write per flush transfer
    logic [CNT_W-1:0] w_fl_dcol, w_fl_col_inc;
    logic [3:0]       w_nib;
    logic [PG_W-1:0]  w_begin_pg;

    assign w_fl_dcol    = w_gx9 + r_fl_col;
    assign w_fl_col_inc = r_fl_col + 1'b1;
    assign w_nib        = 4'(LAST_PG - r_fl_page);
    assign w_begin_pg   = PG_W'(i_fld.y >> 3);

    always_comb begin
        logic [7:0] cbyte;
        logic       pg_end;
        n_fl_page   = r_fl_page;
        n_fl_col    = r_fl_col;
        n_fl_phase  = r_fl_phase;
        n_pend_cmd  = r_pend_cmd;
        n_pend_byte = r_pend_byte;
        n_pend_last = r_pend_last;
        pg_end      = 1'b0;
        cbyte       = '0;
        if (i_cmd.begin_rgn) begin
            n_fl_page  = w_begin_pg;
            n_fl_col   = '0;
            n_fl_phase = (w_begin_pg < PAGES_C) ? PH_ADDR : PH_IDLE;
        end else if (i_cmd.flush_step) begin
            n_pend_last = 1'b0;
            n_fl_col    = w_fl_col_inc;
            if (r_fl_phase == PH_ADDR) begin
                case (r_fl_col[1:0])
                    2'd0:    cbyte = CMD_PAGE | {4'h0, w_nib};
                    2'd1:    cbyte = CMD_COL_HI | {5'h0, r_gx[6:4]};
                    default: cbyte = {4'h0, r_gx[3:0]};
                endcase
                n_pend_cmd  = 1'b1;
                n_pend_byte = rev8(cbyte);
                if (r_fl_col == CNT_W'(ADDR_CMDS - 1)) begin
                    if (w_dc != '0) begin
                        n_fl_col   = '0;
                        n_fl_phase = PH_DATA;
                    end else begin
                        pg_end = 1'b1;
                    end
                end
            end else begin
                n_pend_cmd = 1'b0;
                if (w_fl_col_inc >= w_dc) pg_end = 1'b1;
            end
            // end of page: move on or finish the refresh
            if (pg_end) begin
                n_fl_col = '0;
                if (r_fl_page >= w_fl_last_pg) begin
                    n_fl_phase  = PH_IDLE;
                    n_pend_last = 1'b1;
                end else begin
                    n_fl_page  = r_fl_page + 1'b1;
                    n_fl_phase = PH_ADDR;
                end
            end
        end
    end

    // memory port selection
    logic              w_rd_en, w_wr_en;
    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr;
    logic [7:0]        w_wr_data;

    always_comb begin
        if (i_cmd.fill_step) begin
            w_rd_addr = mem_addr(r_fp, w_fcol);
        end else if (i_cmd.draw_step) begin
            w_rd_addr = mem_addr(w_dpg, w_dcol);
        end else begin
            w_rd_addr = mem_addr(r_fl_page, w_fl_dcol);
        end
    end

    assign w_rd_en = i_cmd.fill_step | (i_cmd.draw_step & w_pix_ok)
                   | (i_cmd.flush_step & (r_fl_phase == PH_DATA));
    assign w_wr_en   = i_cmd.clr_step | r_wr_pend;
    assign w_wr_addr = i_cmd.clr_step ? r_clr_addr : r_wr_addr;
    assign w_wr_data = i_cmd.clr_step ? 8'h00
                     : ((r_rd_data & ~r_wr_mask) | (r_wr_mask & {8{r_wr_bit}}));

    // frame memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rd_data <= r_mem[w_rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx        <= '0;
            r_gy        <= '0;
            r_gw        <= '0;
            r_gh        <= '0;
            r_gfill     <= 1'b0;
            r_src_k     <= '0;
            r_src_row   <= '0;
            r_bit       <= '0;
            r_fp        <= '0;
            r_fi        <= '0;
            r_fl_page   <= '0;
            r_fl_col    <= '0;
            r_fl_phase  <= PH_IDLE;
            r_clr_addr  <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fl_page  <= n_fl_page;
            r_fl_col   <= n_fl_col;
            r_fl_phase <= n_fl_phase;
            r_wr_pend  <= i_cmd.fill_step | (i_cmd.draw_step & w_pix_ok);

            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;

            // latch a new region
            if (i_cmd.begin_rgn) begin
                r_gx      <= i_fld.x;
                r_gy      <= i_fld.y;
                r_gw      <= i_fld.w;
                r_gh      <= i_fld.h;
                r_gfill   <= i_fld.fill_mode;
                r_src_k   <= '0;
                r_src_row <= '0;
                r_fp      <= w_begin_pg;
                r_fi      <= '0;
            end

            // fill walk, columns inside pages
            if (i_cmd.fill_step) begin
                if (r_fi == w_dc - 1'b1) begin
                    r_fi <= '0;
                    r_fp <= r_fp + 1'b1;
                end else begin
                    r_fi <= r_fi + 1'b1;
                end
            end

            // source walk, bits inside bytes inside rows
            if (i_cmd.src_start) begin
                r_bit <= '0;
            end else if (i_cmd.draw_step) begin
                r_bit <= r_bit + 1'b1;
                if (r_bit == 3'd7) begin
                    if (w_k_inc == w_rb) begin
                        r_src_k   <= '0;
                        r_src_row <= r_src_row + 1'b1;
                    end else begin
                        r_src_k <= r_src_k + 1'b1;
                    end
                end
            end

            // output handshake
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_cmd  <= n_pend_cmd;
        r_pend_byte <= n_pend_byte;
        r_pend_last <= n_pend_last;
        if (i_cmd.begin_rgn) r_gpat <= i_fld.fill_byte;
        if (i_cmd.src_start) r_src_byte <= i_fld.src_byte;
        if (i_cmd.fill_step) begin
            r_wr_addr <= w_rd_addr;
            r_wr_mask <= w_fmask;
            r_wr_bit  <= w_fbit;
        end else if (i_cmd.draw_step) begin
            r_wr_addr <= w_rd_addr;
            r_wr_mask <= w_dmask;
            r_wr_bit  <= w_dbit;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_pend_cmd ? r_pend_byte : r_rd_data;
            r_out_cmd  <= r_pend_cmd;
            r_out_last <= r_pend_last;
        end
    end

    // status to the controller
    assign o_stat.clr_done   = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_stat.fill_empty = (r_gh == '0) || (w_dc == '0) || (w_top_pg >= PAGES_C);
    assign o_stat.fill_last  = (r_fi == w_dc - 1'b1) && (r_fp == w_fill_last_pg);
    assign o_stat.src_ok     = !r_gfill && (w_rb != '0) && (r_src_row < r_gh);
    assign o_stat.draw_last  = (r_bit == 3'd7);
    assign o_stat.flush_has  = (r_fl_phase != PH_IDLE);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_cmd;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/page_framebuffer_blit_refresh.sv =====
// top level of the page framebuffer blit and refresh block
//
//  channel   direction  payload                                      transfer when
//  s_axis    in         tuser cmd, tdata region/pattern/source byte  tvalid & tready
//  m_axis    out        tuser command flag, tdata pin byte, tlast    tvalid & tready
//
// items are serialised by the single read-modify-write path through the frame memory:
//   a begin in draw mode only latches the region, a begin in fill mode then walks every
//   clipped column of every covered page, a source byte makes eight pixel updates
//   plus accept and write-back, and a flush may wait for the output register
// after reset a clearing pass writes zero to all PAGES * COLUMNS (1024) bytes, one a
//   cycle, with tready low; reset is synchronous and active low
// a result waiting in the output register does not stall items other than flush
module page_framebuffer_blit_refresh
    import pfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: x[6:0], y[12:7], w[20:13], h[27:21], fill_mode[28], fill_byte[36:29],
    //        src_byte[44:37], zero pad[47:45]
    input  logic [47:0] i_s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: bus_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    // tuser: is_command[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    t_fields  w_fld;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // unpack the input payload
    assign w_fld.x         = i_s_axis_tdata[6:0];
    assign w_fld.y         = i_s_axis_tdata[12:7];
    assign w_fld.w         = i_s_axis_tdata[20:13];
    assign w_fld.h         = i_s_axis_tdata[27:21];
    assign w_fld.fill_mode = i_s_axis_tdata[28];
    assign w_fld.fill_byte = i_s_axis_tdata[36:29];
    assign w_fld.src_byte  = i_s_axis_tdata[44:37];

    pfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_cmd_code  (t_cmd'(i_s_axis_tuser)),
        .i_fill_mode (w_fld.fill_mode),
        .i_stat      (w_stat),
        .o_ready     (o_s_axis_tready),
        .o_cmd       (w_cmd)
    );

    pfb_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_fld      (w_fld),
        .i_m_tready (i_m_axis_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tlast  (o_m_axis_tlast)
    );

    // the clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready right after reset");

    // a refresh step only advances on an input transfer
    a_flush_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.flush_step |-> (i_s_axis_tvalid && o_s_axis_tready))
        else $error("refresh step without input transfer");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register overwritten");

endmodule
